// File: rtl/bitmap_first_fit_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap first-fit block allocator
// Shared helpers for the concurrent checks of the allocator.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define BFFBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define BFFBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bffba_pkg.sv
// ----------------------------------------------------------------------------
// bffba_pkg
// Command and status codes and the broadcast control bundle of the allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bffba_pkg;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Status codes
  localparam int STS_W = 3;
  localparam logic [STS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STS_W-1:0] STS_ZERO      = 3'd1;
  localparam logic [STS_W-1:0] STS_TOO_BIG   = 3'd2;
  localparam logic [STS_W-1:0] STS_NO_SPACE  = 3'd3;
  localparam logic [STS_W-1:0] STS_NOT_ALLOC = 3'd4;

  // Field widths at the ports
  localparam int SIZE_W   = 16;
  localparam int BLK_W    = 7;
  localparam int OFFSET_W = 12;
  localparam int COUNT_W  = 8;

  // Operation held by the controller and broadcast to every cell
  typedef struct packed {
    logic              cmd;
    logic [SIZE_W-1:0] size;
    logic [BLK_W-1:0]  blk;
    logic              commit;
  } ctl_t;

endpackage

// File: rtl/bffba_cell.sv
// ----------------------------------------------------------------------------
// bffba_cell
// One block of the page: its free bit, its recorded run length, and one stage
// of the scan wavefront that travels from block 0 upward, one cell a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bffba_cell #(
  parameter int IDX         = 0,
  parameter int BLOCK_BYTES = 32,
  parameter int IW          = 7,
  parameter int CW          = 8,
  parameter int AW          = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  bffba_pkg::ctl_t  ctl,
  input  logic [IW-1:0]    lo,
  input  logic [IW-1:0]    hi,
  input  logic [CW-1:0]    need,
  input  logic             i_tok,
  input  logic             i_stop,
  input  logic [CW-1:0]    i_run,
  input  logic [AW-1:0]    i_acc,
  input  logic [IW-1:0]    i_at,
  output logic             o_tok,
  output logic             o_stop,
  output logic [CW-1:0]    o_run,
  output logic [AW-1:0]    o_acc,
  output logic [IW-1:0]    o_at
);
  import bffba_pkg::*;

  logic          free;
  logic          free_next;
  logic [CW-1:0] len;
  logic [CW-1:0] len_next;
  logic          stop_next;
  logic [CW-1:0] run_next;
  logic [AW-1:0] acc_next;
  logic [IW-1:0] at_next;

  // Scan step and state update
  always_comb begin
    free_next = free;
    len_next  = len;
    stop_next = i_stop;
    run_next  = i_run;
    acc_next  = i_acc;
    at_next   = i_at;
    if (i_tok) begin
      if (ctl.cmd == CMD_ALLOC) begin
        // first fit: extend the current run, hit once it covers the size
        if (!i_stop) begin
          if (free) begin
            run_next = i_run + CW'(1);
            acc_next = i_acc + AW'(BLOCK_BYTES);
            if (int'(acc_next) >= int'(ctl.size)) begin
              stop_next = 1'b1;
              at_next   = IW'(IDX);
            end
          end else begin
            run_next = '0;
            acc_next = '0;
          end
        end
      end else begin
        // free: the start cell hands its length on, the run behind it follows
        if (!i_stop && (int'(ctl.blk) == IDX) && (len != '0)) begin
          stop_next = 1'b1;
          run_next  = len;
          len_next  = '0;
          free_next = 1'b1;
        end else if (i_stop && ((IDX - int'(ctl.blk)) < int'(i_run))) begin
          free_next = 1'b1;
        end
      end
    end
    // commit of a found run: mark used, record length at the start
    if (ctl.commit) begin
      if ((IW'(IDX) >= lo) && (IW'(IDX) <= hi)) begin
        free_next = 1'b0;
      end
      if (IW'(IDX) == lo) begin
        len_next = need;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      o_tok <= 1'b0;
      free  <= 1'b1;
      len   <= '0;
    end else begin
      o_tok <= i_tok;
      free  <= free_next;
      len   <= len_next;
    end
  end

  // Wavefront payload
  always_ff @(posedge clk) begin
    o_stop <= stop_next;
    o_run  <= run_next;
    o_acc  <= acc_next;
    o_at   <= at_next;
  end

endmodule

// File: rtl/bitmap_first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator
// First-fit contiguous block allocator over a page tracked by a free bitmap.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result beat
// appears with done high for a single cycle and cannot be held off. An
// allocate with zero size or a size above the page answers on the cycle after
// acceptance. Every other command sends a wavefront through the row of
// NUM_BLOCKS block cells at one cell per cycle: a free, or an allocate that
// finds no room, answers after the wavefront leaves the last cell, and a
// successful allocate first passes through one commit state. The chain
// length alone sets the latency. A new command may be started in the cycle
// its predecessor's done is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_first_fit_block_allocator #(
  parameter int NUM_BLOCKS  = 128,
  parameter int BLOCK_BYTES = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command,
  input  logic [bffba_pkg::SIZE_W-1:0]         size_bytes,
  input  logic [bffba_pkg::BLK_W-1:0]          start_block,
  output logic                                 done,
  output logic [bffba_pkg::STS_W-1:0]          status,
  output logic [bffba_pkg::BLK_W-1:0]          block_index,
  output logic [bffba_pkg::OFFSET_W-1:0]       byte_offset,
  output logic [bffba_pkg::COUNT_W-1:0]        block_count
);
  import bffba_pkg::*;

  localparam int PAGE_BYTES = NUM_BLOCKS * BLOCK_BYTES;
  localparam int IW         = $clog2(NUM_BLOCKS);
  localparam int CW         = $clog2(NUM_BLOCKS + 1);
  localparam int AW         = $clog2(PAGE_BYTES + BLOCK_BYTES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]        state;
  logic              inj;
  logic              cmd_q;
  logic [SIZE_W-1:0] size_q;
  logic [BLK_W-1:0]  blk_q;
  logic [IW-1:0]     lo_q;
  logic [IW-1:0]     hi_q;
  logic [CW-1:0]     need_q;
  ctl_t              ctl;

  // Wavefront links, entry k feeds cell k
  logic          w_tok  [NUM_BLOCKS+1];
  logic          w_stop [NUM_BLOCKS+1];
  logic [CW-1:0] w_run  [NUM_BLOCKS+1];
  logic [AW-1:0] w_acc  [NUM_BLOCKS+1];
  logic [IW-1:0] w_at   [NUM_BLOCKS+1];

  logic          accept;
  logic          fin;
  logic [2:0]    fin_sts;
  logic [IW-1:0] fin_idx;
  logic [CW-1:0] fin_cnt;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign ctl.cmd    = cmd_q;
  assign ctl.size   = size_q;
  assign ctl.blk    = blk_q;
  assign ctl.commit = (state == ST_COMMIT);

  // Head of the chain
  assign w_tok[0]  = inj;
  assign w_stop[0] = 1'b0;
  assign w_run[0]  = '0;
  assign w_acc[0]  = '0;
  assign w_at[0]   = '0;

  // Row of block cells
  genvar g;
  generate
    for (g = 0; g < NUM_BLOCKS; g++) begin : g_cell
      bffba_cell #(
        .IDX         (g),
        .BLOCK_BYTES (BLOCK_BYTES),
        .IW          (IW),
        .CW          (CW),
        .AW          (AW)
      ) u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .lo     (lo_q),
        .hi     (hi_q),
        .need   (need_q),
        .i_tok  (w_tok[g]),
        .i_stop (w_stop[g]),
        .i_run  (w_run[g]),
        .i_acc  (w_acc[g]),
        .i_at   (w_at[g]),
        .o_tok  (w_tok[g+1]),
        .o_stop (w_stop[g+1]),
        .o_run  (w_run[g+1]),
        .o_acc  (w_acc[g+1]),
        .o_at   (w_at[g+1])
      );
    end
  endgenerate

  // Result selection for the beat that ends this cycle
  always_comb begin
    fin     = 1'b0;
    fin_sts = STS_OK;
    fin_idx = '0;
    fin_cnt = '0;
    case (state)
      ST_IDLE: begin
        if (accept && (command == CMD_ALLOC)) begin
          if (int'(size_bytes) > PAGE_BYTES) begin
            fin     = 1'b1;
            fin_sts = STS_TOO_BIG;
          end else if (size_bytes == '0) begin
            fin     = 1'b1;
            fin_sts = STS_ZERO;
          end
        end
      end
      ST_SCAN: begin
        if (w_tok[NUM_BLOCKS]) begin
          if (cmd_q == CMD_FREE) begin
            fin = 1'b1;
            if (w_stop[NUM_BLOCKS]) begin
              fin_idx = IW'(blk_q);
              fin_cnt = w_run[NUM_BLOCKS];
            end else begin
              fin_sts = STS_NOT_ALLOC;
            end
          end else if (!w_stop[NUM_BLOCKS]) begin
            fin     = 1'b1;
            fin_sts = STS_NO_SPACE;
          end
        end
      end
      ST_COMMIT: begin
        fin     = 1'b1;
        fin_idx = lo_q;
        fin_cnt = need_q;
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  // Controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      inj   <= 1'b0;
      done  <= 1'b0;
    end else begin
      inj  <= 1'b0;
      done <= fin;
      case (state)
        ST_IDLE: begin
          if (accept && !fin) begin
            inj   <= 1'b1;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (w_tok[NUM_BLOCKS]) begin
            state <= fin ? ST_IDLE : ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Command capture, commit range and result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= command;
      size_q <= size_bytes;
      blk_q  <= start_block;
    end
    if (state == ST_SCAN) begin
      lo_q   <= w_at[NUM_BLOCKS] - IW'(w_run[NUM_BLOCKS]) + IW'(1);
      hi_q   <= w_at[NUM_BLOCKS];
      need_q <= w_run[NUM_BLOCKS];
    end
    if (fin) begin
      status      <= fin_sts;
      block_index <= BLK_W'(fin_idx);
      byte_offset <= OFFSET_W'(int'(fin_idx) * BLOCK_BYTES);
      block_count <= COUNT_W'(fin_cnt);
    end
  end

endmodule

// File: rtl/bffba_checker.sv
// ----------------------------------------------------------------------------
// bffba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_first_fit_block_allocator_macros.svh"

module bffba_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           start,
  input logic                           busy,
  input logic                           done,
  input logic [bffba_pkg::STS_W-1:0]    status,
  input logic [bffba_pkg::BLK_W-1:0]    block_index,
  input logic [bffba_pkg::OFFSET_W-1:0] byte_offset,
  input logic [bffba_pkg::COUNT_W-1:0]  block_count
);
  import bffba_pkg::*;

  // an accepted command either answers at once or keeps the block busy
  `BFFBA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy || done, "accept lost")

  // the block only goes idle with a result beat
  `BFFBA_ASSERT_NOW(a_idle_done, clk, rst, $fell(busy), done, "busy fell without a beat")

  // error beats carry zero payload
  `BFFBA_ASSERT_NOW(a_err_zero, clk, rst, done && (status != STS_OK), (block_index == '0) && (byte_offset == '0) && (block_count == '0), "error beat with payload")

  // successful beats move at least one block
  `BFFBA_ASSERT_NOW(a_ok_count, clk, rst, done && (status == STS_OK), block_count != '0, "ok beat with no blocks")

endmodule

bind bitmap_first_fit_block_allocator bffba_checker u_bffba_checker (.*);
